// File: hw/rtl/macd_pkg.sv
`default_nettype none

package macd_pkg;

   localparam int PRICE_WIDTH_DEFAULT = 32;
   localparam int WEIGHT_FRAC_DEFAULT = 16;
   localparam int WEIGHT_WIDTH        = 16;
   localparam int CSR_INDEX_WIDTH     = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_WEIGHT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOW_WEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SIGNAL_WEIGHT = 2'd2;

   localparam logic [WEIGHT_WIDTH-1:0] FAST_WEIGHT_RESET   = 16'd10082;
   localparam logic [WEIGHT_WIDTH-1:0] SLOW_WEIGHT_RESET   = 16'd4855;
   localparam logic [WEIGHT_WIDTH-1:0] SIGNAL_WEIGHT_RESET = 16'd13107;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_BUY  = 2'd1;
   localparam logic [1:0] ACT_SELL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_LINE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_FAST,
      OP_SLOW,
      OP_SIGNAL
   } operand_type;

   typedef struct packed {
      logic load_diff;
      logic load_prod;
      logic signed_range;
   } unit_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/macd_ewma_unit.sv
`default_nettype none

module macd_ewma_unit #(
   parameter int PRICE_WIDTH      = macd_pkg::PRICE_WIDTH_DEFAULT,
   parameter int WEIGHT_FRAC_BITS = macd_pkg::WEIGHT_FRAC_DEFAULT
) (
   input  logic                                clock,
   input  macd_pkg::unit_ctrl_type             ctrl,
   input  logic signed [PRICE_WIDTH+1:0]       x,
   input  logic signed [PRICE_WIDTH+1:0]       avg,
   input  logic        [macd_pkg::WEIGHT_WIDTH-1:0] weight,
   output logic signed [PRICE_WIDTH:0]         result
);
   import macd_pkg::*;

   localparam int DW = PRICE_WIDTH + 2;
   localparam int MW = PRICE_WIDTH + 1;
   localparam int RW = MW + WEIGHT_WIDTH;
   localparam int SW = RW + 2;

   logic signed [DW-1:0] diff;
   logic signed [DW-1:0] neg_diff;
   logic                 neg_ff, neg_in;
   logic [MW-1:0]        mag_ff, mag_in;
   logic [RW-1:0]        prod_ff, prod_in;
   logic [RW-1:0]        step;
   logic signed [SW-1:0] step_pos;
   logic signed [SW-1:0] step_s;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] hi;
   logic signed [SW-1:0] lo;

   // The step is the magnitude of the difference times the weight, truncated,
   // with the sign put back afterwards, so that it rounds toward zero.
   always_comb begin
      diff     = x - avg;
      neg_diff = -diff;
      neg_in   = diff[DW-1];
      mag_in   = neg_in ? neg_diff[MW-1:0] : diff[MW-1:0];
      prod_in  = RW'(mag_ff) * RW'(weight);
      step     = prod_ff >> WEIGHT_FRAC_BITS;
      step_pos = $signed({2'b00, step});
      step_s   = neg_ff ? -step_pos : step_pos;
      sum      = SW'(avg) + step_s;
      hi       = $signed({{(SW-PRICE_WIDTH){1'b0}}, {PRICE_WIDTH{1'b1}}});
      lo       = ctrl.signed_range ? -hi : '0;
      if (sum > hi) begin
         result = hi[MW-1:0];
      end else if (sum < lo) begin
         result = lo[MW-1:0];
      end else begin
         result = sum[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_diff) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/macd_crossover_signal.sv
// An accepted price passes through the fast and slow updates, LINE and the signal update
// before OUT makes its result valid; the first price after reset goes straight to OUT and only seeds the averages.
// A new price is taken only in IDLE, after the last one has left OUT; the three averages are
// updated one after another on one shared subtract, multiply and accumulate unit.
// While an earlier result is held by a stall the finished one waits, and the input with it.
// Reset is synchronous and active high: weights return to their defaults, the
// position goes flat and the next price is treated as the first.
`default_nettype none

module macd_crossover_signal #(
   parameter int PRICE_WIDTH      = macd_pkg::PRICE_WIDTH_DEFAULT,
   parameter int WEIGHT_FRAC_BITS = macd_pkg::WEIGHT_FRAC_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic        [PRICE_WIDTH-1:0]            req_close_price,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [PRICE_WIDTH:0]              rsp_macd_line,
   output logic signed [PRICE_WIDTH:0]              rsp_signal_line,
   output logic signed [PRICE_WIDTH+2:0]            rsp_histogram,
   output logic                                     rsp_cross_up,
   output logic                                     rsp_cross_down,
   output logic        [1:0]                        rsp_action,
   output logic                                     rsp_holding,
   input  logic                                     csr_write,
   input  logic        [macd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [macd_pkg::WEIGHT_WIDTH-1:0] csr_wdata
);
   import macd_pkg::*;

   localparam int LW = PRICE_WIDTH + 1;
   localparam int XW = PRICE_WIDTH + 2;

   state_type   state_ff, state_in;
   operand_type sel_ff, sel_in;

   logic [WEIGHT_WIDTH-1:0] fast_w_ff, slow_w_ff, signal_w_ff;
   logic started_ff, long_ff, long_in;
   logic rsp_valid_ff;

   logic [PRICE_WIDTH-1:0] price_ff, fast_ff, slow_ff;
   logic signed [LW-1:0]   signal_ff, line_ff, prev_line_ff, prev_signal_ff;

   logic signed [LW-1:0]   rsp_line_ff, rsp_signal_ff;
   logic signed [LW+1:0]   rsp_hist_ff;
   logic                   rsp_up_ff, rsp_down_ff, rsp_holding_ff;
   logic [1:0]             rsp_action_ff, action_in;

   logic                   accept;
   logic                   out_free;
   logic                   out_load;
   logic                   golden, death;
   logic signed [LW:0]     line_minus_sig;
   logic signed [LW+1:0]   hist_in;

   unit_ctrl_type             unit_ctrl;
   logic signed [XW-1:0]      unit_x, unit_avg;
   logic [WEIGHT_WIDTH-1:0]   unit_w;
   logic signed [LW-1:0]      unit_result;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sel_in   = OP_FAST;
               state_in = started_ff ? ST_DIFF : ST_OUT;
            end
         end
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC: begin
            case (sel_ff)
               OP_FAST: begin
                  sel_in   = OP_SLOW;
                  state_in = ST_DIFF;
               end
               OP_SLOW: state_in = ST_LINE;
               default: state_in = ST_OUT;
            endcase
         end
         ST_LINE: begin
            sel_in   = OP_SIGNAL;
            state_in = ST_DIFF;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall              = (state_ff != ST_IDLE);
      unit_ctrl.load_diff    = (state_ff == ST_DIFF);
      unit_ctrl.load_prod    = (state_ff == ST_MUL);
      unit_ctrl.signed_range = (sel_ff == OP_SIGNAL);
      out_load               = (state_ff == ST_OUT) && out_free;
   end

   always_comb begin
      case (sel_ff)
         OP_FAST: begin
            unit_x   = $signed({2'b00, price_ff});
            unit_avg = $signed({2'b00, fast_ff});
            unit_w   = fast_w_ff;
         end
         OP_SLOW: begin
            unit_x   = $signed({2'b00, price_ff});
            unit_avg = $signed({2'b00, slow_ff});
            unit_w   = slow_w_ff;
         end
         default: begin
            unit_x   = XW'(line_ff);
            unit_avg = XW'(signal_ff);
            unit_w   = signal_w_ff;
         end
      endcase
   end

   macd_ewma_unit #(
      .PRICE_WIDTH      (PRICE_WIDTH),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_ewma (
      .clock  (clock),
      .ctrl   (unit_ctrl),
      .x      (unit_x),
      .avg    (unit_avg),
      .weight (unit_w),
      .result (unit_result)
   );

   // A buy needs a flat position and a sell a long one, so both cannot occur together.
   always_comb begin
      golden         = (prev_line_ff <= prev_signal_ff) && (line_ff > signal_ff);
      death          = (prev_line_ff >= prev_signal_ff) && (line_ff < signal_ff);
      line_minus_sig = (LW+1)'(line_ff) - (LW+1)'(signal_ff);
      hist_in        = {line_minus_sig, 1'b0};
      long_in        = long_ff;
      action_in      = ACT_NONE;
      if (golden && (line_ff < 0) && !long_ff) begin
         long_in   = 1'b1;
         action_in = ACT_BUY;
      end else if (death && (line_ff > 0) && long_ff) begin
         long_in   = 1'b0;
         action_in = ACT_SELL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= OP_FAST;
         fast_w_ff    <= FAST_WEIGHT_RESET;
         slow_w_ff    <= SLOW_WEIGHT_RESET;
         signal_w_ff  <= SIGNAL_WEIGHT_RESET;
         started_ff   <= 1'b0;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         if (csr_write) begin
            case (csr_index)
               REG_FAST_WEIGHT:   fast_w_ff   <= csr_wdata;
               REG_SLOW_WEIGHT:   slow_w_ff   <= csr_wdata;
               REG_SIGNAL_WEIGHT: signal_w_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            started_ff <= 1'b1;
         end
         if (out_load) begin
            long_ff      <= long_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         price_ff <= req_close_price;
         if (!started_ff) begin
            fast_ff   <= req_close_price;
            slow_ff   <= req_close_price;
            signal_ff <= '0;
            line_ff   <= '0;
         end
      end
      if (state_ff == ST_ACC) begin
         case (sel_ff)
            OP_FAST: fast_ff   <= unit_result[PRICE_WIDTH-1:0];
            OP_SLOW: slow_ff   <= unit_result[PRICE_WIDTH-1:0];
            default: signal_ff <= unit_result;
         endcase
      end
      if (state_ff == ST_LINE) begin
         line_ff <= $signed({1'b0, fast_ff}) - $signed({1'b0, slow_ff});
      end
      if (out_load) begin
         prev_line_ff   <= line_ff;
         prev_signal_ff <= signal_ff;
         rsp_line_ff    <= line_ff;
         rsp_signal_ff  <= signal_ff;
         rsp_hist_ff    <= hist_in;
         rsp_up_ff      <= golden;
         rsp_down_ff    <= death;
         rsp_action_ff  <= action_in;
         rsp_holding_ff <= long_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_macd_line   = rsp_line_ff;
   assign rsp_signal_line = rsp_signal_ff;
   assign rsp_histogram   = rsp_hist_ff;
   assign rsp_cross_up    = rsp_up_ff;
   assign rsp_cross_down  = rsp_down_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_holding     = rsp_holding_ff;

endmodule

`default_nettype wire

// File: hw/rtl/macd_check.sv
`default_nettype none

module macd_check #(
   parameter int PRICE_WIDTH = macd_pkg::PRICE_WIDTH_DEFAULT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [PRICE_WIDTH:0]   rsp_macd_line,
   input logic signed [PRICE_WIDTH:0]   rsp_signal_line,
   input logic signed [PRICE_WIDTH+2:0] rsp_histogram,
   input logic                        rsp_cross_up,
   input logic                        rsp_cross_down,
   input logic [1:0]                  rsp_action,
   input logic                        rsp_holding
);
   import macd_pkg::*;

   localparam int HW = PRICE_WIDTH + 3;

   logic signed [HW-1:0] line_diff;
   logic signed [HW-1:0] hist_expect;

   assign line_diff   = HW'(rsp_macd_line) - HW'(rsp_signal_line);
   assign hist_expect = {line_diff[HW-2:0], 1'b0};

   // The block is busy once it has taken an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready straight after taking an item");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_macd_line)
         && $stable(rsp_action) && $stable(rsp_holding))
      else $error("stalled result changed");

   a_buy_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_BUY) |->
         rsp_holding && rsp_cross_up && rsp_macd_line[PRICE_WIDTH])
      else $error("buy without an upward cross below zero");

   a_sell_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_SELL) |->
         !rsp_holding && rsp_cross_down && !rsp_macd_line[PRICE_WIDTH])
      else $error("sell without a downward cross above zero");

   a_histogram: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_histogram == hist_expect) && !(rsp_cross_up && rsp_cross_down))
      else $error("histogram or cross flags inconsistent");

endmodule

bind macd_crossover_signal macd_check #(
   .PRICE_WIDTH (PRICE_WIDTH)
) u_macd_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_macd_line   (rsp_macd_line),
   .rsp_signal_line (rsp_signal_line),
   .rsp_histogram   (rsp_histogram),
   .rsp_cross_up    (rsp_cross_up),
   .rsp_cross_down  (rsp_cross_down),
   .rsp_action      (rsp_action),
   .rsp_holding     (rsp_holding)
);

`default_nettype wire
